// ===== src/upn_pkg.sv =====
package upn_pkg;

    // Characters the normalizer looks for
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_DOT     = 8'h2E;

    // Final status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_ESCAPE = 3'd1,
        ST_ZERO       = 3'd2,
        ST_NOT_ABS    = 3'd3,
        ST_DOTDOT     = 3'd4
    } status_t;

    // Percent-escape progress
    typedef enum logic [1:0] {
        ESC_IDLE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } esc_phase_t;

    // Segment progress
    typedef enum logic [1:0] {
        SEG_BOUND  = 2'd0,
        SEG_DOT    = 2'd1,
        SEG_DOTDOT = 2'd2,
        SEG_TEXT   = 2'd3
    } seg_phase_t;

    // One emit command from front to back: '/', then dots, then data, then status
    typedef struct packed {
        logic       pre_slash;
        logic [1:0] dots;
        logic       has_data;
        logic [7:0] data;
        logic       fin;
        status_t    stat;
    } cmd_t;

endpackage

// ===== src/upn_front.sv =====
module upn_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    in_byte,
    input  logic          has_byte,
    input  logic          last,
    input  logic          q_full,
    output logic          push,
    output upn_pkg::cmd_t push_cmd
);

    // Hex digit decode: {is_hex, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    upn_pkg::esc_phase_t esc_reg, esc_next, esc_mid;
    logic [3:0]          high_reg, high_next, high_mid;
    logic                seen_reg, seen_next, seen_mid;
    upn_pkg::seg_phase_t seg_reg, seg_next, seg_mid;
    logic                emitted_reg, emitted_next, emitted_mid;
    upn_pkg::status_t    err_reg, err_next, err_mid, dec_err, norm_err, fin_err;

    logic       accept;
    logic       d_valid;
    logic [7:0] d;
    logic [4:0] hx;
    logic       emit_data;
    logic       final_slash;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign hx       = hex_decode(in_byte);

    // Percent decode
    always_comb
    begin
        esc_mid  = esc_reg;
        high_mid = high_reg;
        dec_err  = upn_pkg::ST_OK;
        d_valid  = 1'b0;
        d        = in_byte;
        if (has_byte && err_reg != upn_pkg::ST_BAD_ESCAPE && err_reg != upn_pkg::ST_ZERO)
        begin
            if (esc_reg == upn_pkg::ESC_IDLE)
            begin
                if (in_byte == upn_pkg::CH_PERCENT)
                    esc_mid = upn_pkg::ESC_HIGH;
                else
                    d_valid = 1'b1;
            end
            else if (!hx[4])
            begin
                dec_err = upn_pkg::ST_BAD_ESCAPE;
                esc_mid = upn_pkg::ESC_IDLE;
            end
            else if (esc_reg == upn_pkg::ESC_HIGH)
            begin
                high_mid = hx[3:0];
                esc_mid  = upn_pkg::ESC_LOW;
            end
            else
            begin
                esc_mid = upn_pkg::ESC_IDLE;
                d       = {high_reg, hx[3:0]};
                if (d == 8'd0)
                    dec_err = upn_pkg::ST_ZERO;
                else
                    d_valid = 1'b1;
            end
        end
    end

    // Segment normalization
    always_comb
    begin
        seen_mid  = seen_reg;
        seg_mid   = seg_reg;
        norm_err  = upn_pkg::ST_OK;
        emit_data = 1'b0;
        if (d_valid && err_reg == upn_pkg::ST_OK)
        begin
            if (!seen_reg)
            begin
                seen_mid = 1'b1;
                if (d != upn_pkg::CH_SLASH)
                    norm_err = upn_pkg::ST_NOT_ABS;
            end
            else if (d == upn_pkg::CH_SLASH)
            begin
                if (seg_reg == upn_pkg::SEG_DOTDOT)
                    norm_err = upn_pkg::ST_DOTDOT;
                else
                    seg_mid = upn_pkg::SEG_BOUND;
            end
            else if (d == upn_pkg::CH_DOT && seg_reg == upn_pkg::SEG_BOUND)
                seg_mid = upn_pkg::SEG_DOT;
            else if (d == upn_pkg::CH_DOT && seg_reg == upn_pkg::SEG_DOT)
                seg_mid = upn_pkg::SEG_DOTDOT;
            else
            begin
                emit_data = 1'b1;
                seg_mid   = upn_pkg::SEG_TEXT;
            end
        end
        emitted_mid = emitted_reg || emit_data;

        if (dec_err != upn_pkg::ST_OK)
            err_mid = dec_err;
        else if (norm_err != upn_pkg::ST_OK)
            err_mid = norm_err;
        else
            err_mid = err_reg;
    end

    // End-of-path status
    always_comb
    begin
        fin_err = err_mid;
        if (err_mid != upn_pkg::ST_BAD_ESCAPE && err_mid != upn_pkg::ST_ZERO
            && esc_mid != upn_pkg::ESC_IDLE)
            fin_err = upn_pkg::ST_BAD_ESCAPE;
        if (fin_err == upn_pkg::ST_OK && !seen_mid)
            fin_err = upn_pkg::ST_NOT_ABS;
        if (fin_err == upn_pkg::ST_OK && seg_mid == upn_pkg::SEG_DOTDOT)
            fin_err = upn_pkg::ST_DOTDOT;
        final_slash = last && fin_err == upn_pkg::ST_OK && !emitted_mid;
    end

    // Next state: the end of a path returns everything to reset
    always_comb
    begin
        esc_next     = esc_reg;
        high_next    = high_reg;
        seen_next    = seen_reg;
        seg_next     = seg_reg;
        emitted_next = emitted_reg;
        err_next     = err_reg;
        if (accept)
        begin
            if (last)
            begin
                esc_next     = upn_pkg::ESC_IDLE;
                high_next    = 4'd0;
                seen_next    = 1'b0;
                seg_next     = upn_pkg::SEG_BOUND;
                emitted_next = 1'b0;
                err_next     = upn_pkg::ST_OK;
            end
            else
            begin
                esc_next     = esc_mid;
                high_next    = high_mid;
                seen_next    = seen_mid;
                seg_next     = seg_mid;
                emitted_next = emitted_mid;
                err_next     = err_mid;
            end
        end
    end

    // Command word for the back end
    always_comb
    begin
        push              = accept && (emit_data || last);
        push_cmd.has_data = emit_data;
        push_cmd.data     = d;
        push_cmd.fin      = last;
        push_cmd.stat     = last ? fin_err : upn_pkg::ST_OK;
        push_cmd.pre_slash = final_slash || (emit_data && seg_reg != upn_pkg::SEG_TEXT);
        push_cmd.dots      = 2'd0;
        if (emit_data)
        begin
            unique case (seg_reg)
                upn_pkg::SEG_DOT:    push_cmd.dots = 2'd1;
                upn_pkg::SEG_DOTDOT: push_cmd.dots = 2'd2;
                default:             push_cmd.dots = 2'd0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg     <= upn_pkg::ESC_IDLE;
            high_reg    <= 4'd0;
            seen_reg    <= 1'b0;
            seg_reg     <= upn_pkg::SEG_BOUND;
            emitted_reg <= 1'b0;
            err_reg     <= upn_pkg::ST_OK;
        end
        else
        begin
            esc_reg     <= esc_next;
            high_reg    <= high_next;
            seen_reg    <= seen_next;
            seg_reg     <= seg_next;
            emitted_reg <= emitted_next;
            err_reg     <= err_next;
        end
    end

endmodule

// ===== src/upn_queue.sv =====
module upn_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  upn_pkg::cmd_t push_cmd,
    input  logic          pop,
    output upn_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    upn_pkg::cmd_t mem [DEPTH];

    logic [AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == FULL_CNT);
    assign head  = mem[rd_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == LAST_PTR) ? '0 : wr_reg + 1'b1;
        if (pop)
            rd_next = (rd_reg == LAST_PTR) ? '0 : rd_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== src/upn_back.sv =====
module upn_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  upn_pkg::cmd_t head,
    input  logic          empty,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    out_byte,
    output logic          byte_valid,
    output logic          end_flag,
    output logic [2:0]    status
);

    upn_pkg::cmd_t cur_reg, cur_next, cur_left;
    logic          cur_valid_reg, cur_valid_next;
    logic          ov_reg, ov_next;
    logic [7:0]    byte_reg, byte_next;
    logic          bv_reg, bv_next;
    logic          ef_reg, ef_next;
    logic [2:0]    st_reg, st_next;
    logic          advance;
    logic          emit;
    logic          done;

    assign advance = !ov_reg || !out_stall;
    assign emit    = cur_valid_reg && advance;

    // Pick the next word of the current command, in order
    always_comb
    begin
        cur_left  = cur_reg;
        byte_next = 8'd0;
        bv_next   = 1'b1;
        ef_next   = 1'b0;
        st_next   = 3'(upn_pkg::ST_OK);
        if (cur_reg.pre_slash)
        begin
            byte_next          = upn_pkg::CH_SLASH;
            cur_left.pre_slash = 1'b0;
        end
        else if (cur_reg.dots != 2'd0)
        begin
            byte_next     = upn_pkg::CH_DOT;
            cur_left.dots = cur_reg.dots - 2'd1;
        end
        else if (cur_reg.has_data)
        begin
            byte_next         = cur_reg.data;
            cur_left.has_data = 1'b0;
        end
        else
        begin
            bv_next      = 1'b0;
            ef_next      = 1'b1;
            st_next      = 3'(cur_reg.stat);
            cur_left.fin = 1'b0;
        end
        done = !(cur_left.pre_slash || cur_left.dots != 2'd0
                 || cur_left.has_data || cur_left.fin);
    end

    // Command register: reload from the queue when the current one is finished
    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        pop            = 1'b0;
        if (emit)
            cur_next = cur_left;
        if (!cur_valid_reg || (emit && done))
        begin
            pop            = !empty;
            cur_valid_next = !empty;
            if (!empty)
                cur_next = head;
        end
    end

    // Output register
    always_comb
    begin
        ov_next = ov_reg;
        if (advance)
            ov_next = emit;
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            byte_reg <= byte_next;
            bv_reg   <= bv_next;
            ef_reg   <= ef_next;
            st_reg   <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            ov_reg        <= ov_next;
        end
    end

    assign out_valid  = ov_reg;
    assign out_byte   = byte_reg;
    assign byte_valid = bv_reg;
    assign end_flag   = ef_reg;
    assign status     = st_reg;

endmodule

// ===== src/url_path_decode_normalize.sv =====
// URL path percent-decoder and normalizer.
// Input channel (in_valid / in_stall): one raw request-target byte per word,
// has_byte = 0 for an end-only marker, last = 1 closing the path.
// Output channel (out_valid / out_stall): normalized path bytes
// (byte_valid = 1), then one status word per path (end_flag = 1, status).
// The front end decodes and classifies one input word per cycle while the queue
// has room, and writes an emit command into a QUEUE_DEPTH-entry queue; the back
// end expands each command into 1 to 5 output words, one per cycle while the
// receiver does not stall, through a command register and an output register.
// Throughput: one input word per cycle while the queue has room; the back end
// gives one output word per cycle unless stalled, so a segment start (up to
// '/..x', four words) or a path end plus status delays the next command.
// in_stall rises only when the queue is full.
// When the receiver stalls, the output word holds and the queue fills, then
// in_stall is raised. Reset empties the queue and output register and
// returns the decoder to the start of a path.
module url_path_decode_normalize
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       has_byte,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       end_flag,
    output logic [2:0] status
);

    upn_pkg::cmd_t push_cmd;
    upn_pkg::cmd_t head;
    logic          push;
    logic          pop;
    logic          empty;
    logic          full;

    upn_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .has_byte (has_byte),
        .last     (last),
        .q_full   (full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    upn_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    upn_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .end_flag   (end_flag),
        .status     (status)
    );

endmodule
